// ===== sv/fas_pkg.sv =====
// Package for the flight arming safety supervisor.
// Holds the mode encoding, fault mask bit positions, register indexes and reset values.
// No dependencies.
package fas_pkg;

   // Mode machine state, one-hot.
   typedef enum logic [3:0] {
      MODE_DISARMED = 4'b0001,
      MODE_ARMING   = 4'b0010,
      MODE_ARMED    = 4'b0100,
      MODE_FAILSAFE = 4'b1000
   } mode_type;

   // Two-bit mode codes as reported on the result channel.
   localparam logic [1:0] CODE_DISARMED = 2'd0;
   localparam logic [1:0] CODE_ARMING   = 2'd1;
   localparam logic [1:0] CODE_ARMED    = 2'd2;
   localparam logic [1:0] CODE_FAILSAFE = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_THROTTLE_LIMIT = 2'd0;
   localparam logic [1:0] REG_IMU_MAX_AGE    = 2'd1;
   localparam logic [1:0] REG_RECOVERY_HOLD  = 2'd2;

   // Register reset values.
   localparam logic [15:0] THROTTLE_LIMIT_RESET = 16'd1100;
   localparam logic [31:0] IMU_MAX_AGE_RESET    = 32'd10000;
   localparam logic [31:0] RECOVERY_HOLD_RESET  = 32'd1000000;

   // Fault mask bit positions.
   localparam int FAULT_RC_INVALID    = 0;
   localparam int FAULT_RC_FAILSAFE   = 1;
   localparam int FAULT_RC_UNHEALTHY  = 2;
   localparam int FAULT_THROTTLE_HIGH = 3;
   localparam int FAULT_IMU_INVALID   = 4;
   localparam int FAULT_UNCALIBRATED  = 5;
   localparam int FAULT_STALE         = 6;
   localparam int FAULT_ARM_OFF       = 7;

   // Maps the one-hot state onto the reported two-bit code.
   function automatic logic [1:0] mode_code(mode_type m);
      logic [1:0] code;
      unique case (m)
         MODE_DISARMED: code = CODE_DISARMED;
         MODE_ARMING:   code = CODE_ARMING;
         MODE_ARMED:    code = CODE_ARMED;
         MODE_FAILSAFE: code = CODE_FAILSAFE;
         default:       code = CODE_DISARMED;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/flight_arming_safety_fsm.sv =====
// Top level of the flight arming safety supervisor: health checks, mode machine,
// failsafe recovery timer and result register. Depends on fas_pkg.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+------------------------------
//   request  | req_valid, req_stall, req_*    | taken when valid and not stall
//   response | rsp_valid, rsp_stall, rsp_*    | taken when valid and not stall
//   config   | csr_valid, csr_ready, csr_*    | written when valid and ready
//
// One item per cycle unless the result stalls; items pass stage one, then the result register.
// Stage one registers the health checks (one 64-bit age compare sets its depth),
// stage two runs the mode machine and the recovery compare into the result register.
// Reset is synchronous and returns the mode to disarmed with the timer idle.
// A stalled result holds the pipe; req_stall rises only while both stages are full.
module flight_arming_safety_fsm
   import fas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_now_us,
   input  logic        req_rc_valid,
   input  logic        req_rc_failsafe,
   input  logic        req_rc_healthy,
   input  logic [15:0] req_throttle,
   input  logic        req_arm_switch,
   input  logic        req_imu_valid,
   input  logic        req_imu_calibrated,
   input  logic [63:0] req_imu_time_us,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_mode,
   output logic [1:0]  rsp_prior_mode,
   output logic [7:0]  rsp_fault_mask,
   output logic        rsp_ready_to_arm,
   output logic        rsp_is_armed,
   output logic [31:0] rsp_change_count,
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Configuration registers
   logic [15:0] throttle_limit_ff;
   logic [31:0] imu_max_age_ff;
   logic [31:0] recovery_hold_ff;

   // Stage one
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_now_ff;
   logic        s1_arm_ff;
   logic        s1_cond_ok_ff;
   logic [7:0]  s1_mask_ff;

   // Supervisor state
   mode_type    mode_ff, mode_in;
   logic [63:0] recovery_start_ff, recovery_start_in;
   logic [31:0] change_count_ff, change_count_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_mode_ff;
   logic [1:0]  rsp_prior_mode_ff;
   logic [7:0]  rsp_fault_mask_ff;
   logic        rsp_ready_to_arm_ff;
   logic        rsp_is_armed_ff;

   logic        s1_advance;
   logic        req_accept;

   logic        thr_low;
   logic [64:0] imu_age;
   logic        fresh;
   logic        cond_ok;
   logic [7:0]  mask;

   logic [64:0] held_time;
   logic        recovery_done;

   // Handshake: stage one moves on whenever the result register is free or drains.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_limit_ff <= THROTTLE_LIMIT_RESET;
         imu_max_age_ff    <= IMU_MAX_AGE_RESET;
         recovery_hold_ff  <= RECOVERY_HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_THROTTLE_LIMIT: throttle_limit_ff <= csr_data[15:0];
            REG_IMU_MAX_AGE:    imu_max_age_ff    <= csr_data;
            REG_RECOVERY_HOLD:  recovery_hold_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Health checks on the incoming item. The IMU data is stale if its stamp is ahead of now.
   always_comb begin
      thr_low = req_throttle <= throttle_limit_ff;
      imu_age = {1'b0, req_now_us} - {1'b0, req_imu_time_us};
      fresh   = req_imu_valid && !imu_age[64] && (imu_age[63:0] <= {32'd0, imu_max_age_ff});
      cond_ok = req_rc_valid && !req_rc_failsafe && req_rc_healthy && thr_low &&
                req_imu_valid && req_imu_calibrated && fresh;
      mask                      = '0;
      mask[FAULT_RC_INVALID]    = !req_rc_valid;
      mask[FAULT_RC_FAILSAFE]   = req_rc_failsafe;
      mask[FAULT_RC_UNHEALTHY]  = !req_rc_healthy;
      mask[FAULT_THROTTLE_HIGH] = !thr_low;
      mask[FAULT_IMU_INVALID]   = !req_imu_valid;
      mask[FAULT_UNCALIBRATED]  = !req_imu_calibrated;
      mask[FAULT_STALE]         = !fresh;
      mask[FAULT_ARM_OFF]       = !req_arm_switch;
   end

   // Stage one valid bit.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_now_ff     <= req_now_us;
         s1_arm_ff     <= req_arm_switch;
         s1_cond_ok_ff <= cond_ok;
         s1_mask_ff    <= mask;
      end
   end

   // Recovery timer compare; the borrow bit flags time running backwards.
   assign held_time     = {1'b0, s1_now_ff} - {1'b0, recovery_start_ff};
   assign recovery_done = s1_cond_ok_ff && !s1_arm_ff && (recovery_start_ff != 64'd0) &&
                          !held_time[64] &&
                          (held_time[63:0] >= {32'd0, recovery_hold_ff});

   // Mode machine and recovery timer update.
   always_comb begin
      mode_in           = mode_ff;
      recovery_start_in = recovery_start_ff;
      unique case (mode_ff)
         MODE_DISARMED: begin
            if (s1_cond_ok_ff && s1_arm_ff) begin
               mode_in = MODE_ARMING;
            end
         end
         MODE_ARMING: begin
            if (!s1_cond_ok_ff) begin
               mode_in = MODE_FAILSAFE;
            end else if (!s1_arm_ff) begin
               mode_in = MODE_DISARMED;
            end else begin
               mode_in = MODE_ARMED;
            end
         end
         MODE_ARMED: begin
            if (!s1_cond_ok_ff) begin
               mode_in = MODE_FAILSAFE;
            end else if (!s1_arm_ff) begin
               mode_in = MODE_DISARMED;
            end
         end
         MODE_FAILSAFE: begin
            if (!s1_cond_ok_ff || s1_arm_ff) begin
               recovery_start_in = '0;
            end else if (recovery_done) begin
               mode_in = MODE_DISARMED;
            end else begin
               // Idle timer or a clock that went backwards: restart at now.
               if (recovery_start_ff == 64'd0 || held_time[64]) begin
                  recovery_start_in = s1_now_ff;
               end
            end
         end
         default: begin
            mode_in = MODE_DISARMED;
         end
      endcase
      if (mode_in != MODE_FAILSAFE) begin
         recovery_start_in = '0;
      end
      change_count_in = change_count_ff;
      if (mode_in != mode_ff) begin
         change_count_in = change_count_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_DISARMED;
         recovery_start_ff <= '0;
         change_count_ff   <= '0;
      end else if (s1_advance) begin
         mode_ff           <= mode_in;
         recovery_start_ff <= recovery_start_in;
         change_count_ff   <= change_count_in;
      end
   end

   // Result register valid bit.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_mode_ff         <= mode_code(mode_in);
         rsp_prior_mode_ff   <= mode_code(mode_ff);
         rsp_fault_mask_ff   <= s1_mask_ff;
         rsp_ready_to_arm_ff <= s1_cond_ok_ff && s1_arm_ff;
         rsp_is_armed_ff     <= mode_in == MODE_ARMED;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_prior_mode   = rsp_prior_mode_ff;
   assign rsp_fault_mask   = rsp_fault_mask_ff;
   assign rsp_ready_to_arm = rsp_ready_to_arm_ff;
   assign rsp_is_armed     = rsp_is_armed_ff;
   assign rsp_change_count = change_count_ff;

endmodule
